// ----- sv/yuyv_pkg.sv -----
// ----------------------------------------------------------------------------
// yuyv_pkg
// Shared types, coefficients and helpers of the YUYV 4:2:2 to RGB packer.
// ----------------------------------------------------------------------------
package yuyv_pkg;

   // Widths of the scaled chroma terms and of the per-channel sums.
   localparam int TERM_W = 18;
   localparam int SUM_W  = 19;

   // Fixed-point conversion factors over 256.
   localparam logic signed [TERM_W-1:0] COEF_RV = 18'sd359;
   localparam logic signed [TERM_W-1:0] COEF_GU = 18'sd88;
   localparam logic signed [TERM_W-1:0] COEF_GV = 18'sd183;
   localparam logic signed [TERM_W-1:0] COEF_BU = 18'sd454;

   // Output packing codes held in the format register.
   localparam logic [1:0] FMT_RGB24 = 2'd0;
   localparam logic [1:0] FMT_BGR24 = 2'd1;
   localparam logic [1:0] FMT_RGB32 = 2'd2;
   localparam logic [1:0] FMT_BGR32 = 2'd3;

   localparam logic [2:0] COUNT_3B = 3'd3;
   localparam logic [2:0] COUNT_4B = 3'd4;

   typedef struct packed {
      logic signed [TERM_W-1:0] red_term;
      logic signed [TERM_W-1:0] green_term;
      logic signed [TERM_W-1:0] blue_term;
   } chroma_terms_type;

   // Arithmetic shift right by 8, then clamp to 0..255.
   function automatic logic [7:0] shift_clamp(input logic signed [SUM_W-1:0] sum);
      logic signed [SUM_W-9:0] q;
      logic [7:0]              res;
      q = $signed(sum[SUM_W-1:8]);
      if (q < 0) begin
         res = 8'h00;
      end else if (q > 255) begin
         res = 8'hFF;
      end else begin
         res = q[7:0];
      end
      return res;
   endfunction

endpackage

// ----- sv/yuyv_chroma.sv -----
// ----------------------------------------------------------------------------
// yuyv_chroma
// Centers the shared U and V samples and scales them into the three
// chroma terms that both pixels of a macropixel use.
// ----------------------------------------------------------------------------
module yuyv_chroma (
   input  logic [7:0]                   chroma_u,
   input  logic [7:0]                   chroma_v,
   output yuyv_pkg::chroma_terms_type   terms
);

   logic signed [7:0]                  u_c;
   logic signed [7:0]                  v_c;
   logic signed [yuyv_pkg::TERM_W-1:0] u_ext;
   logic signed [yuyv_pkg::TERM_W-1:0] v_ext;

   // Offset binary minus 128 is just the top bit inverted.
   assign u_c   = $signed({~chroma_u[7], chroma_u[6:0]});
   assign v_c   = $signed({~chroma_v[7], chroma_v[6:0]});
   assign u_ext = yuyv_pkg::TERM_W'(u_c);
   assign v_ext = yuyv_pkg::TERM_W'(v_c);

   always_comb begin
      terms.red_term   = yuyv_pkg::COEF_RV * v_ext;
      terms.green_term = -(yuyv_pkg::COEF_GU * u_ext) - (yuyv_pkg::COEF_GV * v_ext);
      terms.blue_term  = yuyv_pkg::COEF_BU * u_ext;
   end

endmodule

// ----- sv/yuyv_pixel_pack.sv -----
// ----------------------------------------------------------------------------
// yuyv_pixel_pack
// Adds one luma sample to the chroma terms, clamps each channel and packs
// the pixel in the byte order that the format register selects.
// ----------------------------------------------------------------------------
module yuyv_pixel_pack (
   input  logic [7:0]                 luma,
   input  yuyv_pkg::chroma_terms_type terms,
   input  logic [1:0]                 output_format,
   output logic [31:0]                pixel_bytes,
   output logic [2:0]                 byte_count
);

   logic signed [yuyv_pkg::SUM_W-1:0] yy;
   logic signed [yuyv_pkg::SUM_W-1:0] sum_r;
   logic signed [yuyv_pkg::SUM_W-1:0] sum_g;
   logic signed [yuyv_pkg::SUM_W-1:0] sum_b;
   logic [7:0]                        red;
   logic [7:0]                        green;
   logic [7:0]                        blue;

   assign yy    = $signed({3'b000, luma, 8'h00});
   assign sum_r = yy + yuyv_pkg::SUM_W'($signed(terms.red_term));
   assign sum_g = yy + yuyv_pkg::SUM_W'($signed(terms.green_term));
   assign sum_b = yy + yuyv_pkg::SUM_W'($signed(terms.blue_term));

   assign red   = yuyv_pkg::shift_clamp(sum_r);
   assign green = yuyv_pkg::shift_clamp(sum_g);
   assign blue  = yuyv_pkg::shift_clamp(sum_b);

   // The top byte is zero in every format: padding or a zero alpha.
   always_comb begin
      case (output_format)
         yuyv_pkg::FMT_RGB24: begin
            pixel_bytes = {8'h00, blue, green, red};
            byte_count  = yuyv_pkg::COUNT_3B;
         end
         yuyv_pkg::FMT_BGR24: begin
            pixel_bytes = {8'h00, red, green, blue};
            byte_count  = yuyv_pkg::COUNT_3B;
         end
         yuyv_pkg::FMT_RGB32: begin
            pixel_bytes = {8'h00, blue, green, red};
            byte_count  = yuyv_pkg::COUNT_4B;
         end
         yuyv_pkg::FMT_BGR32: begin
            pixel_bytes = {8'h00, red, green, blue};
            byte_count  = yuyv_pkg::COUNT_4B;
         end
         default: begin
            pixel_bytes = {8'h00, blue, green, red};
            byte_count  = yuyv_pkg::COUNT_3B;
         end
      endcase
   end

endmodule

// ----- sv/yuyv422_to_rgb_packer.sv -----
// ----------------------------------------------------------------------------
// yuyv422_to_rgb_packer
// Converts packed YUYV 4:2:2 macropixels into two packed RGB pixel words.
//
// The req_ channel takes one macropixel per word (first luma, U, second
// luma, V). The rsp_ channel gives two words per macropixel: the first pixel
// with rsp_pair_last low, then the second with rsp_pair_last high. Each word
// holds the pixel in RGB24, BGR24, RGB32 or BGR32 order as the format
// register (csr_wr_en / csr_wr_data) selects; the top byte is always zero.
// Write the format only while the block is empty.
// A macropixel passes from the input register to the pixel pair register, which
// feeds the result register with its first pixel and then, unless the receiver
// stalls, with its second; the pair register frees only once the single result
// port has taken both. The input register takes the next macropixel while the current pair drains.
// When the receiver stalls, the output word holds and the stall backs up
// through the pixel pair stage to req_stall.
// Reset empties all stages and sets the format to RGB24.
// ----------------------------------------------------------------------------
module yuyv422_to_rgb_packer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_luma_first,
   input  logic [7:0]  req_chroma_u,
   input  logic [7:0]  req_luma_second,
   input  logic [7:0]  req_chroma_v,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_pixel_bytes,
   output logic [2:0]  rsp_byte_count,
   output logic        rsp_pair_last,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data
);

   logic [1:0] fmt_ff;

   // Input register.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_luma0_ff, in_luma1_ff, in_u_ff, in_v_ff;

   // Pixel pair register: chroma terms and both lumas.
   logic                       pair_valid_ff, pair_valid_in;
   logic                       pair_half_ff, pair_half_in;
   logic [7:0]                 pair_luma0_ff, pair_luma1_ff;
   yuyv_pkg::chroma_terms_type pair_terms_ff, terms_in;

   // Result register.
   logic        out_valid_ff, out_valid_in;
   logic [31:0] out_bytes_ff, out_bytes_in;
   logic [2:0]  out_count_ff, out_count_in;
   logic        out_last_ff;

   logic       out_load, pair_take, pair_free, in_free, req_accept;
   logic [7:0] luma_sel;

   assign out_load   = !out_valid_ff || !rsp_stall;
   assign pair_take  = pair_valid_ff && out_load;
   assign pair_free  = !pair_valid_ff || (pair_take && pair_half_ff);
   assign in_free    = !in_valid_ff || pair_free;
   assign req_stall  = !in_free;
   assign req_accept = req_valid && in_free;

   yuyv_chroma u_chroma (
      .chroma_u (in_u_ff),
      .chroma_v (in_v_ff),
      .terms    (terms_in)
   );

   assign luma_sel = pair_half_ff ? pair_luma1_ff : pair_luma0_ff;

   yuyv_pixel_pack u_pack (
      .luma          (luma_sel),
      .terms         (pair_terms_ff),
      .output_format (fmt_ff),
      .pixel_bytes   (out_bytes_in),
      .byte_count    (out_count_in)
   );

   always_comb begin
      in_valid_in = in_free ? req_accept : in_valid_ff;

      pair_valid_in = pair_valid_ff;
      pair_half_in  = pair_half_ff;
      if (pair_free) begin
         pair_valid_in = in_valid_ff;
         pair_half_in  = 1'b0;
      end else if (pair_take) begin
         pair_half_in  = 1'b1;
      end

      out_valid_in = out_load ? pair_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_ff        <= yuyv_pkg::FMT_RGB24;
         in_valid_ff   <= 1'b0;
         pair_valid_ff <= 1'b0;
         pair_half_ff  <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            fmt_ff <= csr_wr_data;
         end
         in_valid_ff   <= in_valid_in;
         pair_valid_ff <= pair_valid_in;
         pair_half_ff  <= pair_half_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_luma0_ff <= req_luma_first;
         in_u_ff     <= req_chroma_u;
         in_luma1_ff <= req_luma_second;
         in_v_ff     <= req_chroma_v;
      end
      if (pair_free && in_valid_ff) begin
         pair_luma0_ff <= in_luma0_ff;
         pair_luma1_ff <= in_luma1_ff;
         pair_terms_ff <= terms_in;
      end
      if (pair_take) begin
         out_bytes_ff <= out_bytes_in;
         out_count_ff <= out_count_in;
         out_last_ff  <= pair_half_ff;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_pixel_bytes = out_bytes_ff;
   assign rsp_byte_count  = out_count_ff;
   assign rsp_pair_last   = out_last_ff;

endmodule

// ----- sv/yuyv_checker.sv -----
// ----------------------------------------------------------------------------
// yuyv_checker
// Port-level checks of the YUYV to RGB packer, bound to the top level.
// ----------------------------------------------------------------------------
module yuyv_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_pixel_bytes,
   input logic        rsp_pair_last
);

   // Reset leaves no word on the result side.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The top byte is padding or a zero alpha in every format.
   a_top_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_pixel_bytes[31:24] == 8'h00))
      else $error("nonzero top byte in pixel word");

   // Once the first pixel of a pair is taken, the second follows at once.
   a_pair_follows: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !rsp_pair_last) |=> (rsp_valid && rsp_pair_last))
      else $error("second pixel of pair did not follow the first");

   // A stalled result word holds.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
         (rsp_valid && $stable(rsp_pixel_bytes) && $stable(rsp_pair_last)))
      else $error("stalled result changed");

endmodule

bind yuyv422_to_rgb_packer yuyv_checker u_yuyv_checker (.*);

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the YUYV 4:2:2 to RGB packer. Macropixels are sent
// through the req_ channel with random gaps. Each accepted word is converted
// by a local color model into two expected pixel words. These are compared
// field by field with the rsp_ words. The run steps through all four output
// formats, and one long receiver hold-off backs the pipeline up to req_stall.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;
   localparam int RANDOM_ITEMS  = 247;
   localparam int PHASES        = 5;
   localparam int HOLD_AFTER    = 200;
   localparam int HOLD_CYCLES   = 100;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] chroma_u;
      logic [7:0] luma_second;
      logic [7:0] chroma_v;
   } macropixel_type;

   typedef struct packed {
      logic [31:0] pixel_bytes;
      logic [2:0]  byte_count;
      logic        pair_last;
   } rgb_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_luma_first = 8'd0;
   logic [7:0]  req_chroma_u = 8'd0;
   logic [7:0]  req_luma_second = 8'd0;
   logic [7:0]  req_chroma_v = 8'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [31:0] rsp_pixel_bytes;
   logic [2:0]  rsp_byte_count;
   logic        rsp_pair_last;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_wr_data = yuyv_pkg::FMT_RGB24;

   macropixel_type pending_macropixels[$];
   rgb_word_type   expected_pixels[$];
   logic [1:0]  format_model = yuyv_pkg::FMT_RGB24;
   logic        quiet_mode = 1'b0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   int          words_seen = 0;
   int          mismatches = 0;
   int          cycle_count = 0;

   yuyv422_to_rgb_packer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_luma_first  (req_luma_first),
      .req_chroma_u    (req_chroma_u),
      .req_luma_second (req_luma_second),
      .req_chroma_v    (req_chroma_v),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pixel_bytes (rsp_pixel_bytes),
      .rsp_byte_count  (rsp_byte_count),
      .rsp_pair_last   (rsp_pair_last),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data)
   );

   always #10 clock = ~clock;

   // Floor division by 256 of a signed channel sum, then saturation to a byte.
   function automatic logic [7:0] channel_byte(input int sum);
      int q;
      q = sum >>> 8;
      if (q < 0) begin
         return 8'h00;
      end else if (q > 255) begin
         return 8'hFF;
      end
      return q[7:0];
   endfunction

   function automatic rgb_word_type convert_pixel(input logic [7:0] luma,
                                                  input logic [7:0] u_raw,
                                                  input logic [7:0] v_raw,
                                                  input logic [1:0] fmt,
                                                  input logic second);
      int           base;
      int           cu;
      int           cv;
      logic [7:0]   red;
      logic [7:0]   green;
      logic [7:0]   blue;
      rgb_word_type word;
      base = luma;
      base = base * 256;
      cu = u_raw;
      cu = cu - 128;
      cv = v_raw;
      cv = cv - 128;
      red   = channel_byte(base + 359 * cv);
      green = channel_byte(base - 88 * cu - 183 * cv);
      blue  = channel_byte(base + 454 * cu);
      if (fmt == yuyv_pkg::FMT_BGR24 || fmt == yuyv_pkg::FMT_BGR32) begin
         word.pixel_bytes = {8'h00, red, green, blue};
      end else begin
         word.pixel_bytes = {8'h00, blue, green, red};
      end
      word.byte_count = (fmt == yuyv_pkg::FMT_RGB32 || fmt == yuyv_pkg::FMT_BGR32) ?
                        yuyv_pkg::COUNT_4B : yuyv_pkg::COUNT_3B;
      word.pair_last = second;
      return word;
   endfunction

   // Bytes lean toward the rails so that clamping is hit often.
   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 7))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   function automatic macropixel_type make_macropixel(input logic [7:0] y0,
                                                      input logic [7:0] u,
                                                      input logic [7:0] y1,
                                                      input logic [7:0] v);
      macropixel_type m;
      m.luma_first  = y0;
      m.chroma_u    = u;
      m.luma_second = y1;
      m.chroma_v    = v;
      return m;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("MISMATCH %s: got %h, expected %h (cycle %0d)", what, got, want, cycle_count);
      mismatches++;
   endtask

   task automatic write_format(input logic [1:0] fmt);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= fmt;
      @(posedge clock);
      format_model = fmt;
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_for_drain();
      while (pending_macropixels.size() != 0 || req_valid || expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Sender: one macropixel word per handshake, with random idle bursts.
   always @(posedge clock) begin : req_driver
      macropixel_type item;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_pixels.push_back(convert_pixel(req_luma_first, req_chroma_u,
                                                    req_chroma_v, format_model, 1'b0));
            expected_pixels.push_back(convert_pixel(req_luma_second, req_chroma_u,
                                                    req_chroma_v, format_model, 1'b1));
         end
         if (!req_valid || !req_stall) begin
            if (send_gap != 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_macropixels.size() != 0) begin
               item = pending_macropixels.pop_front();
               req_luma_first  <= item.luma_first;
               req_chroma_u    <= item.chroma_u;
               req_luma_second <= item.luma_second;
               req_chroma_v    <= item.chroma_v;
               req_valid       <= 1'b1;
               if (!quiet_mode && $urandom_range(0, 5) == 0) begin
                  send_gap <= $urandom_range(1, 6);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: checks each accepted word and stalls in random bursts.
   always @(posedge clock) begin : rsp_checker
      rgb_word_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            words_seen <= words_seen + 1;
            if (expected_pixels.size() == 0) begin
               report_mismatch("word with nothing expected", rsp_pixel_bytes, 32'h0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_pixel_bytes !== want.pixel_bytes) begin
                  report_mismatch("pixel_bytes", rsp_pixel_bytes, want.pixel_bytes);
               end
               if (rsp_byte_count !== want.byte_count) begin
                  report_mismatch("byte_count", 32'(rsp_byte_count), 32'(want.byte_count));
               end
               if (rsp_pair_last !== want.pair_last) begin
                  report_mismatch("pair_last", 32'(rsp_pair_last), 32'(want.pair_last));
               end
            end
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
         end else if (recv_gap != 0) begin
            rsp_stall <= 1'b1;
            recv_gap  <= recv_gap - 1;
         end else if (!quiet_mode && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            recv_gap  <= $urandom_range(0, 5);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // One long hold-off on the result side once traffic is flowing, so that
   // the pipeline fills and pushes back on the sender.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && words_seen >= HOLD_AFTER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin : stimulus
      logic [1:0] phase_format[PHASES];
      phase_format[0] = yuyv_pkg::FMT_RGB24;
      phase_format[1] = yuyv_pkg::FMT_BGR32;
      phase_format[2] = yuyv_pkg::FMT_BGR24;
      phase_format[3] = yuyv_pkg::FMT_RGB32;
      phase_format[4] = yuyv_pkg::FMT_RGB24;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int phase = 0; phase < PHASES; phase++) begin
         quiet_mode = (phase == PHASES - 1);
         write_format(phase_format[phase]);
         if (phase == 0) begin
            // Rails of every field, neutral chroma, and the chroma corners
            // that drive each channel into both clamps.
            pending_macropixels.push_back(make_macropixel(8'h00, 8'h00, 8'h00, 8'h00));
            pending_macropixels.push_back(make_macropixel(8'hFF, 8'hFF, 8'hFF, 8'hFF));
            pending_macropixels.push_back(make_macropixel(8'h00, 8'h80, 8'hFF, 8'h80));
            pending_macropixels.push_back(make_macropixel(8'hFF, 8'h80, 8'h00, 8'h80));
            pending_macropixels.push_back(make_macropixel(8'h80, 8'h00, 8'h80, 8'h00));
            pending_macropixels.push_back(make_macropixel(8'h80, 8'hFF, 8'h80, 8'hFF));
            pending_macropixels.push_back(make_macropixel(8'h00, 8'hFF, 8'h00, 8'h00));
            pending_macropixels.push_back(make_macropixel(8'hFF, 8'h00, 8'hFF, 8'hFF));
            pending_macropixels.push_back(make_macropixel(8'h00, 8'h00, 8'hFF, 8'hFF));
            pending_macropixels.push_back(make_macropixel(8'hFF, 8'hFF, 8'h00, 8'h00));
            pending_macropixels.push_back(make_macropixel(8'h10, 8'h80, 8'hEB, 8'h80));
            pending_macropixels.push_back(make_macropixel(8'h4C, 8'h54, 8'h95, 8'hFF));
            pending_macropixels.push_back(make_macropixel(8'h1D, 8'hFF, 8'hE1, 8'h6B));
            pending_macropixels.push_back(make_macropixel(8'h55, 8'hAA, 8'hAA, 8'h55));
            pending_macropixels.push_back(make_macropixel(8'h7F, 8'h7F, 8'h81, 8'h81));
            pending_macropixels.push_back(make_macropixel(8'h01, 8'h01, 8'hFE, 8'hFE));
         end
         repeat (RANDOM_ITEMS) begin
            pending_macropixels.push_back(make_macropixel(random_byte(), random_byte(),
                                                          random_byte(), random_byte()));
         end
         wait_for_drain();
      end
      while (expected_pixels.size() != 0) begin
         report_mismatch("word never received", expected_pixels[0].pixel_bytes, 32'h0);
         void'(expected_pixels.pop_front());
      end
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
sv/yuyv_pkg.sv
sv/yuyv_chroma.sv
sv/yuyv_pixel_pack.sv
sv/yuyv422_to_rgb_packer.sv
sv/yuyv_checker.sv
bench/tb.sv
